FILE: hw/rtl/hse_pkg.sv
// shared types and constants for the heap sort engine
`default_nettype none

package hse_pkg;

  localparam int unsigned VAL_W = 32;

  typedef logic signed [VAL_W-1:0] value_t;

endpackage

`default_nettype wire

FILE: hw/rtl/heap_sort_engine_top.sv
// heap sort engine: loads a set of signed words, heap sorts them in place, streams them out
//
// Input channel (in_valid_i / in_stall_o, value_i, last_item_i): one word per cycle is
// taken while the block is loading. A word that finds the store full (MAX_ITEMS held) is
// dropped and flags the set. The word with last_item_i set closes the set and starts the sort.
// Sorting runs on one shared compare unit and a store with one write and one registered read
// port (one write, one read per cycle); in_stall_o stays high from the last word until the
// last result is taken. Each sift level reads the left child, then the right child, compares
// them and moves the larger one up if it beats the carried word, paced by the one read port.
// Output channel (out_valid_o / out_stall_i): N words in ascending order, each read from the
// store once the word before is taken; last_out_o on the greatest, overflow_o on every word
// of a set that lost words. A stalled result holds in the output register until taken.
// Reset empties the set and clears the output valid; the store itself is not cleared.
`default_nettype none

module heap_sort_engine_top
  import hse_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  wire  logic   clk_i,
  input  wire  logic   rst_ni,
  input  wire  logic   in_valid_i,
  output logic         in_stall_o,
  input  wire  value_t value_i,
  input  wire  logic   last_item_i,
  output logic         out_valid_o,
  input  wire  logic   out_stall_i,
  output value_t       sorted_value_o,
  output logic         last_out_o,
  output logic         overflow_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned LW    = IDX_W + 2;

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_FETCH = 4'd1;
  localparam logic [3:0] S_CARRY = 4'd2;
  localparam logic [3:0] S_RDL   = 4'd3;
  localparam logic [3:0] S_RDR   = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_PUT   = 4'd7;
  localparam logic [3:0] S_SRD0  = 4'd8;
  localparam logic [3:0] S_SRDI  = 4'd9;
  localparam logic [3:0] S_SWR   = 4'd10;
  localparam logic [3:0] S_ORD   = 4'd11;
  localparam logic [3:0] S_OLD   = 4'd12;
  localparam logic [3:0] S_OWT   = 4'd13;

  value_t store_mem [MAX_ITEMS];
  value_t rd_q;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             sorting_q, sorting_d;
  logic [IDX_W-1:0] i_q, i_d;
  logic [IDX_W-1:0] hole_q, hole_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [IDX_W-1:0] big_q, big_d;
  value_t           carry_q, carry_d;
  value_t           left_q, left_d;
  value_t           bigval_q, bigval_d;
  logic             out_valid_q, out_valid_d;
  value_t           out_val_q, out_val_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;

  logic             we;
  logic [IDX_W-1:0] waddr;
  value_t           wdata;
  logic [IDX_W-1:0] raddr;

  logic [LW-1:0]    lc, rc, big_lc, last_w;
  logic             full;
  logic [CNT_W-1:0] n_w;
  logic [IDX_W-1:0] nlast_w;
  value_t           cmp_a, cmp_b;
  logic             cmp_gt;

  assign lc      = LW'({hole_q, 1'b1});
  assign rc      = lc + LW'(1);
  assign big_lc  = LW'({big_q, 1'b1});
  assign last_w  = LW'(last_q);
  assign full    = (cnt_q == CNT_W'(MAX_ITEMS));
  assign n_w     = full ? cnt_q : cnt_q + CNT_W'(1);
  assign nlast_w = IDX_W'(n_w - CNT_W'(1));

  // one signed comparator: right child vs left child, then larger child vs carried word
  assign cmp_a  = (state_q == S_CMP) ? rd_q   : bigval_q;
  assign cmp_b  = (state_q == S_CMP) ? left_q : carry_q;
  assign cmp_gt = (cmp_a > cmp_b);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    sorting_d   = sorting_q;
    i_d         = i_q;
    hole_d      = hole_q;
    last_d      = last_q;
    big_d       = big_q;
    carry_d     = carry_q;
    left_d      = left_q;
    bigval_d    = bigval_q;
    out_valid_d = out_valid_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    we          = 1'b0;
    waddr       = hole_q;
    wdata       = carry_q;
    raddr       = '0;

    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            we    = 1'b1;
            waddr = cnt_q[IDX_W-1:0];
            wdata = value_i;
          end
          cnt_d = n_w;
          if (last_item_i) begin
            sorting_d = 1'b0;
            last_d    = nlast_w;
            if (n_w == CNT_W'(1)) begin
              i_d     = '0;
              state_d = S_ORD;
            end else begin
              i_d     = (nlast_w - IDX_W'(1)) >> 1;
              hole_d  = (nlast_w - IDX_W'(1)) >> 1;
              state_d = S_FETCH;
            end
          end
        end
      end
      S_FETCH: begin
        raddr   = hole_q;
        state_d = S_CARRY;
      end
      S_CARRY: begin
        carry_d = rd_q;
        state_d = (lc <= last_w) ? S_RDL : S_PUT;
      end
      S_RDL: begin
        raddr   = lc[IDX_W-1:0];
        state_d = S_RDR;
      end
      S_RDR: begin
        left_d = rd_q;
        if (rc <= last_w) begin
          raddr   = rc[IDX_W-1:0];
          state_d = S_CMP;
        end else begin
          big_d    = lc[IDX_W-1:0];
          bigval_d = rd_q;
          state_d  = S_DEC;
        end
      end
      S_CMP: begin
        if (cmp_gt) begin
          big_d    = rc[IDX_W-1:0];
          bigval_d = rd_q;
        end else begin
          big_d    = lc[IDX_W-1:0];
          bigval_d = left_q;
        end
        state_d = S_DEC;
      end
      S_DEC: begin
        // larger child moves up into the hole if it beats the carried word, else the sift ends
        if (cmp_gt) begin
          we      = 1'b1;
          wdata   = bigval_q;
          hole_d  = big_q;
          state_d = (big_lc <= last_w) ? S_RDL : S_PUT;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        we = 1'b1;
        if (!sorting_q) begin
          if (i_q == '0) begin
            sorting_d = 1'b1;
            i_d       = IDX_W'(cnt_q - CNT_W'(1));
            state_d   = S_SRD0;
          end else begin
            i_d     = i_q - IDX_W'(1);
            hole_d  = i_q - IDX_W'(1);
            state_d = S_FETCH;
          end
        end else if (i_q == IDX_W'(1)) begin
          i_d     = '0;
          state_d = S_ORD;
        end else begin
          i_d     = i_q - IDX_W'(1);
          state_d = S_SRD0;
        end
      end
      S_SRD0: begin
        raddr   = '0;
        state_d = S_SRDI;
      end
      S_SRDI: begin
        left_d  = rd_q;
        raddr   = i_q;
        state_d = S_SWR;
      end
      S_SWR: begin
        // old root goes to the tail, tail word sifts down from the root
        we      = 1'b1;
        waddr   = i_q;
        wdata   = left_q;
        carry_d = rd_q;
        hole_d  = '0;
        last_d  = i_q - IDX_W'(1);
        state_d = (i_q == IDX_W'(1)) ? S_PUT : S_RDL;
      end
      S_ORD: begin
        raddr   = i_q;
        state_d = S_OLD;
      end
      S_OLD: begin
        out_valid_d = 1'b1;
        out_val_d   = rd_q;
        out_last_d  = (CNT_W'(i_q) + CNT_W'(1) == cnt_q);
        out_ovf_d   = drop_q;
        state_d     = S_OWT;
      end
      S_OWT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            state_d = S_LOAD;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = S_ORD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[waddr] <= wdata;
    end
    rd_q <= store_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      sorting_q   <= 1'b0;
      i_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      sorting_q   <= sorting_d;
      i_q         <= i_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hole_q     <= hole_d;
    last_q     <= last_d;
    big_q      <= big_d;
    carry_q    <= carry_d;
    left_q     <= left_d;
    bigval_q   <= bigval_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign in_stall_o     = (state_q != S_LOAD);
  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_val_q;
  assign last_out_o     = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule

`default_nettype wire

FILE: hw/rtl/hse_checker.sv
// port-level checks for the heap sort engine, bound to its top level
`default_nettype none

module hse_checker
  import hse_pkg::*;
(
  input wire logic   clk_i,
  input wire logic   rst_ni,
  input wire logic   in_stall_o,
  input wire logic   out_valid_o,
  input wire logic   out_stall_i,
  input wire value_t sorted_value_o,
  input wire logic   last_out_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_value_o))
    else $error("stalled result word changed or vanished");

  // no input word is taken while a result is pending
  a_no_load_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is pending");

  // more words follow a non-final result, so input stays closed
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_out_o |=> in_stall_o)
    else $error("input reopened before the final result");

  // after the final word the block is back to loading
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_out_o |=> !out_valid_o && !in_stall_o)
    else $error("block did not return to loading after the final word");

endmodule

bind heap_sort_engine_top hse_checker u_hse_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sorted_value_o (sorted_value_o),
  .last_out_o     (last_out_o)
);

`default_nettype wire

FILE: verif/tb_top.sv
// testbench for the heap sort engine: random signed sets checked against a sorting predictor
`timescale 1ns / 100ps

module tb_top;
  import hse_pkg::*;

  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned PHASE_WORDS = 150;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    value_t val;
    logic   fin;
  } in_word_t;

  typedef struct packed {
    value_t val;
    logic   fin;
    logic   ovf;
  } sorted_word_t;

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_stall_o;
  value_t value_i     = '0;
  logic   last_item_i = 1'b0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  value_t sorted_value_o;
  logic   last_out_o;
  logic   overflow_o;

  in_word_t     send_q[$];
  sorted_word_t sorted_q[$];

  // predictor copy of the set being loaded
  value_t      set_vals [MAX_ITEMS];
  int unsigned set_count   = 0;
  logic        set_dropped = 1'b0;

  int unsigned  send_idle_pct = 12;
  int unsigned  recv_idle_pct = 79;
  int unsigned  n_mismatch    = 0;
  logic         in_taken      = 1'b0;
  in_word_t     next_w;
  sorted_word_t head_w;

  always #5 clk_i = ~clk_i;

  heap_sort_engine_top #(
    .MAX_ITEMS(MAX_ITEMS)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .value_i       (value_i),
    .last_item_i   (last_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sorted_value_o(sorted_value_o),
    .last_out_o    (last_out_o),
    .overflow_o    (overflow_o)
  );

  // store the word, and on the closing word queue the whole set in ascending order
  function automatic void predict_sorted_run(value_t v, logic fin);
    value_t srt [MAX_ITEMS];
    value_t key;
    int     n;
    int     j;
    if (set_count < MAX_ITEMS) begin
      set_vals[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!fin) return;
    n = set_count;
    for (int i = 0; i < n; i++) srt[i] = set_vals[i];
    for (int i = 1; i < n; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    for (int k = 0; k < n; k++) begin
      sorted_q.push_back('{val: srt[k], fin: (k == n - 1), ovf: set_dropped});
    end
    set_count   = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic value_t rand_value();
    value_t r;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: r = 32'sh8000_0000;
          1: r = 32'sh7fff_ffff;
          2: r = '0;
          default: r = -1;
        endcase
      end
      // narrow range so duplicates show up
      1, 2: r = int'($urandom_range(0, 15)) - 8;
      default: r = $urandom();
    endcase
    return r;
  endfunction

  task automatic push_word(value_t v, logic fin);
    send_q.push_back('{val: v, fin: fin});
  endtask

  task automatic push_set(int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_word(rand_value(), i == n - 1);
  endtask

  // one forced set size first, then random sets, mostly small
  task automatic fill_phase(int unsigned first_n);
    int unsigned words;
    int unsigned n;
    push_set(first_n);
    words = first_n;
    while (words < PHASE_WORDS) begin
      case ($urandom_range(0, 19))
        0: n = MAX_ITEMS;
        1: n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
        default: n = $urandom_range(1, 12);
      endcase
      push_set(n);
      words += n;
    end
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (send_q.size() != 0 || in_valid_i || sorted_q.size() != 0) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_q.size() == 0 || $urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
      end else begin
        next_w = send_q.pop_front();
        in_valid_i  <= 1'b1;
        value_i     <= next_w.val;
        last_item_i <= next_w.fin;
      end
    end
  end

  // output stall
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // monitor: predict on accepted input words, check accepted output words
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) predict_sorted_run(value_i, last_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sorted_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_REPORTS) begin
          $display("unexpected word: value %0d last %0b ovf %0b",
                   sorted_value_o, last_out_o, overflow_o);
        end
      end else begin
        head_w = sorted_q.pop_front();
        if (sorted_value_o !== head_w.val || last_out_o !== head_w.fin ||
            overflow_o !== head_w.ovf) begin
          n_mismatch++;
          if (n_mismatch <= MAX_REPORTS) begin
            $display("mismatch: expected value %0d last %0b ovf %0b, got value %0d last %0b ovf %0b",
                     head_w.val, head_w.fin, head_w.ovf,
                     sorted_value_o, last_out_o, overflow_o);
          end
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-word sets at both extremes
    push_word(32'sh7fff_ffff, 1'b1);
    push_word(32'sh8000_0000, 1'b1);
    // mixed extremes and signs
    push_word(32'sh7fff_ffff, 1'b0);
    push_word(0, 1'b0);
    push_word(-1, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(1, 1'b0);
    push_word(-2, 1'b1);
    // duplicates
    push_word(5, 1'b0);
    push_word(-5, 1'b0);
    push_word(5, 1'b0);
    push_word(5, 1'b0);
    push_word(-5, 1'b1);
    push_word(9, 1'b0);
    push_word(9, 1'b1);
    // already descending
    push_word(4, 1'b0);
    push_word(3, 1'b0);
    push_word(2, 1'b0);
    push_word(1, 1'b1);
    // alternating bit patterns
    push_word(32'sh5555_5555, 1'b0);
    push_word(32'shaaaa_aaaa, 1'b1);

    // store exactly full
    fill_phase(MAX_ITEMS);
    wait_drained();

    send_idle_pct = 79;
    recv_idle_pct = 12;
    // closing word itself finds the store full
    fill_phase(MAX_ITEMS + 1);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_phase(MAX_ITEMS + 3);
    wait_drained();

    repeat (60) @(posedge clk_i);
    n_mismatch += sorted_q.size();
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/hse_pkg.sv
hw/rtl/heap_sort_engine_top.sv
hw/rtl/hse_checker.sv
verif/tb_top.sv
